// File: hw/rtl/rgpid_pkg.sv
// Shared types and constants for the rate-gated PID controller.
package rgpid_pkg;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegPropGain  = 3'd0;
  localparam logic [RegIdxW-1:0] RegIntegGain = 3'd1;
  localparam logic [RegIdxW-1:0] RegDerivGain = 3'd2;
  localparam logic [RegIdxW-1:0] RegStepMs    = 3'd3;
  localparam logic [RegIdxW-1:0] RegIntegLim  = 3'd4;

  localparam logic [15:0] StepMsReset   = 16'd10;
  localparam logic [30:0] IntegLimReset = 31'h7FFF_FFFF;

  localparam logic signed [49:0] SatMax = 50'sh0_0000_7FFF_FFFF;
  localparam logic signed [49:0] SatMin = -50'sh0_0000_8000_0000;
  localparam logic signed [65:0] RoundHalf = 66'sh8000;

  localparam int unsigned DivStepsW = 5;
  localparam logic [DivStepsW-1:0] DivLast = 5'd31;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_HOLD,
    S_MUL_P,
    S_ACC_P,
    S_MUL_E,
    S_CLAMP,
    S_MUL_I,
    S_ACC_I,
    S_DIV_INIT,
    S_DIV,
    S_MUL_D,
    S_ACC_D,
    S_ROUND
  } state_t;

endpackage

// File: hw/rtl/rate_gated_pid_controller.sv
// Rate-gated PID controller with clamped integral on one shared multiplier and divider.
//
// The input channel (in_valid/in_ready) carries a command, an error sample and
// a millisecond timestamp. The result channel (out_valid/out_ready) returns one
// item per input item: the control value and a flag telling whether it was
// recomputed. The user must write gains, step and integral limit over the APB
// port only while the block is idle; the block does not enforce this. Reads
// return the stored values. A held item (too little time elapsed) passes
// through the check and hold states before its result is written. A PID update
// (command 0) also passes through the integral states; a PD update (command 1)
// skips them. Most of an update is spent in the restoring division of the
// derivative; the rest is one pass per product through the single 33x33
// multiplier and its accumulate. With zero elapsed time the division is
// skipped. One item is processed at a time; in_ready is high only while the
// sequencer is idle.
// Reset clears all controller state and loads the register defaults
// (gains 0, step 10, limit 2^31-1). If the receiver stalls, the finished
// result waits in the output register; the next item is still accepted, and
// its sequence waits before writing its own result.
module rate_gated_pid_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic signed [15:0]            in_error_in,
  input  logic [31:0]                   in_now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_control_value,
  output logic                          out_recomputed,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rgpid_pkg::AddrW-1:0]   paddr,
  input  logic [rgpid_pkg::DataW-1:0]   pwdata,
  output logic [rgpid_pkg::DataW-1:0]   prdata,
  output logic                          pready
);

  rgpid_pkg::state_t state_r, state_nxt;

  logic signed [31:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [15:0]        step_ms_r;
  logic [30:0]        integ_limit_r;

  logic signed [15:0] prev_err_r, prev_err_nxt;
  logic signed [31:0] int_sum_r, int_sum_nxt;
  logic [31:0]        last_ms_r, last_ms_nxt;
  logic signed [31:0] held_r, held_nxt;

  logic               cmd_r;
  logic signed [15:0] err_r;
  logic [31:0]        now_r;
  logic [31:0]        dt_r, dt_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic signed [65:0] acc_r, acc_nxt;

  logic [32:0]                        div_rem_r, div_rem_nxt;
  logic [31:0]                        div_q_r, div_q_nxt;
  logic                               div_neg_r, div_neg_nxt;
  logic [rgpid_pkg::DivStepsW-1:0]    div_cnt_r, div_cnt_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [31:0]                 out_val_r, out_val_nxt;
  logic                               out_rec_r, out_rec_nxt;

  logic                      in_acc, slot_free, cfg_wr;
  logic [rgpid_pkg::RegIdxW-1:0] cfg_idx;
  logic [31:0]               dt_calc;
  logic                      dt_due;
  logic signed [16:0]        diff17, diff_mag;
  logic [33:0]               div_trial;
  logic [32:0]               rem_sh;
  logic signed [32:0]        deriv33;
  logic signed [50:0]        sum_e, lim51;
  logic signed [65:0]        rnd;
  logic signed [49:0]        rnd50;

  assign in_ready  = (state_r == rgpid_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_control_value = out_val_r;
  assign out_recomputed    = out_rec_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[rgpid_pkg::AddrW-1:2];

  always_comb begin
    case (cfg_idx)
      rgpid_pkg::RegPropGain:  prdata = prop_gain_r;
      rgpid_pkg::RegIntegGain: prdata = integ_gain_r;
      rgpid_pkg::RegDerivGain: prdata = deriv_gain_r;
      rgpid_pkg::RegStepMs:    prdata = {16'd0, step_ms_r};
      rgpid_pkg::RegIntegLim:  prdata = {1'b0, integ_limit_r};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      deriv_gain_r  <= '0;
      step_ms_r     <= rgpid_pkg::StepMsReset;
      integ_limit_r <= rgpid_pkg::IntegLimReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rgpid_pkg::RegPropGain:  prop_gain_r   <= pwdata;
        rgpid_pkg::RegIntegGain: integ_gain_r  <= pwdata;
        rgpid_pkg::RegDerivGain: deriv_gain_r  <= pwdata;
        rgpid_pkg::RegStepMs:    step_ms_r     <= pwdata[15:0];
        rgpid_pkg::RegIntegLim:  integ_limit_r <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  assign dt_calc  = now_r - last_ms_r;
  assign dt_due   = (dt_calc >= {16'd0, step_ms_r});
  assign diff17   = {err_r[15], err_r} - {prev_err_r[15], prev_err_r};
  assign diff_mag = diff17[16] ? -diff17 : diff17;
  assign rem_sh   = {div_rem_r[31:0], div_q_r[31]};
  assign div_trial = {1'b0, rem_sh} - {2'b00, dt_r};
  assign deriv33  = div_neg_r ? -$signed({1'b0, div_q_r}) : $signed({1'b0, div_q_r});
  assign sum_e    = {{19{int_sum_r[31]}}, int_sum_r} + prod_r[50:0];
  assign lim51    = $signed({20'd0, integ_limit_r});
  assign rnd      = acc_r + rgpid_pkg::RoundHalf;
  assign rnd50    = rnd[65:16];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rgpid_pkg::S_IDLE:     if (in_acc) state_nxt = rgpid_pkg::S_CHECK;
      rgpid_pkg::S_CHECK:    state_nxt = dt_due ? rgpid_pkg::S_MUL_P : rgpid_pkg::S_HOLD;
      rgpid_pkg::S_HOLD:     if (slot_free) state_nxt = rgpid_pkg::S_IDLE;
      rgpid_pkg::S_MUL_P:    state_nxt = rgpid_pkg::S_ACC_P;
      rgpid_pkg::S_ACC_P:    state_nxt = cmd_r ? rgpid_pkg::S_DIV_INIT : rgpid_pkg::S_MUL_E;
      rgpid_pkg::S_MUL_E:    state_nxt = rgpid_pkg::S_CLAMP;
      rgpid_pkg::S_CLAMP:    state_nxt = rgpid_pkg::S_MUL_I;
      rgpid_pkg::S_MUL_I:    state_nxt = rgpid_pkg::S_ACC_I;
      rgpid_pkg::S_ACC_I:    state_nxt = rgpid_pkg::S_DIV_INIT;
      rgpid_pkg::S_DIV_INIT: state_nxt = (dt_r == 32'd0) ? rgpid_pkg::S_MUL_D
                                                         : rgpid_pkg::S_DIV;
      rgpid_pkg::S_DIV:      if (div_cnt_r == rgpid_pkg::DivLast) state_nxt = rgpid_pkg::S_MUL_D;
      rgpid_pkg::S_MUL_D:    state_nxt = rgpid_pkg::S_ACC_D;
      rgpid_pkg::S_ACC_D:    state_nxt = rgpid_pkg::S_ROUND;
      rgpid_pkg::S_ROUND:    if (slot_free) state_nxt = rgpid_pkg::S_IDLE;
      default:               state_nxt = rgpid_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    acc_nxt       = acc_r;
    dt_nxt        = dt_r;
    prev_err_nxt  = prev_err_r;
    int_sum_nxt   = int_sum_r;
    last_ms_nxt   = last_ms_r;
    held_nxt      = held_r;
    div_rem_nxt   = div_rem_r;
    div_q_nxt     = div_q_r;
    div_neg_nxt   = div_neg_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_rec_nxt   = out_rec_r;
    case (state_r)
      rgpid_pkg::S_CHECK: begin
        dt_nxt = dt_calc;
      end
      rgpid_pkg::S_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = held_r;
          out_rec_nxt   = 1'b0;
        end
      end
      rgpid_pkg::S_MUL_P: begin
        mul_a = {prop_gain_r[31], prop_gain_r};
        mul_b = {{17{err_r[15]}}, err_r};
      end
      rgpid_pkg::S_ACC_P: begin
        acc_nxt = prod_r;
      end
      rgpid_pkg::S_MUL_E: begin
        mul_a = {{17{err_r[15]}}, err_r};
        mul_b = $signed({1'b0, dt_r});
      end
      rgpid_pkg::S_CLAMP: begin
        if (sum_e > lim51) begin
          int_sum_nxt = lim51[31:0];
        end else if (sum_e < -lim51) begin
          int_sum_nxt = -lim51[31:0];
        end else begin
          int_sum_nxt = sum_e[31:0];
        end
      end
      rgpid_pkg::S_MUL_I: begin
        mul_a = {integ_gain_r[31], integ_gain_r};
        mul_b = {int_sum_r[31], int_sum_r};
      end
      rgpid_pkg::S_ACC_I: begin
        acc_nxt = acc_r + prod_r;
      end
      rgpid_pkg::S_DIV_INIT: begin
        div_rem_nxt = '0;
        div_cnt_nxt = '0;
        div_neg_nxt = diff17[16];
        div_q_nxt   = (dt_r == 32'd0) ? 32'd0 : {diff_mag[15:0], 16'd0};
      end
      rgpid_pkg::S_DIV: begin
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (!div_trial[33]) begin
          div_rem_nxt = div_trial[32:0];
          div_q_nxt   = {div_q_r[30:0], 1'b1};
        end else begin
          div_rem_nxt = rem_sh;
          div_q_nxt   = {div_q_r[30:0], 1'b0};
        end
      end
      rgpid_pkg::S_MUL_D: begin
        mul_a = {deriv_gain_r[31], deriv_gain_r};
        mul_b = deriv33;
      end
      rgpid_pkg::S_ACC_D: begin
        acc_nxt = acc_r + {{16{prod_r[65]}}, prod_r[65:16]};
      end
      rgpid_pkg::S_ROUND: begin
        if (slot_free) begin
          if (rnd50 > rgpid_pkg::SatMax) begin
            held_nxt = rgpid_pkg::SatMax[31:0];
          end else if (rnd50 < rgpid_pkg::SatMin) begin
            held_nxt = rgpid_pkg::SatMin[31:0];
          end else begin
            held_nxt = rnd50[31:0];
          end
          prev_err_nxt  = err_r;
          last_ms_nxt   = now_r;
          out_valid_nxt = 1'b1;
          out_val_nxt   = held_nxt;
          out_rec_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rgpid_pkg::S_IDLE;
      prev_err_r  <= '0;
      int_sum_r   <= '0;
      last_ms_r   <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_err_r  <= prev_err_nxt;
      int_sum_r   <= int_sum_nxt;
      last_ms_r   <= last_ms_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_command;
      err_r <= in_error_in;
      now_r <= in_now_ms;
    end
    prod_r    <= mul_a * mul_b;
    acc_r     <= acc_nxt;
    dt_r      <= dt_nxt;
    div_rem_r <= div_rem_nxt;
    div_q_r   <= div_q_nxt;
    div_neg_r <= div_neg_nxt;
    div_cnt_r <= div_cnt_nxt;
    out_val_r <= out_val_nxt;
    out_rec_r <= out_rec_nxt;
  end

  // A waiting result always matches the stored held output.
  a_out_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_val_r == held_r))
    else $error("output register differs from held output");

  // Accepting an item makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("block ready right after accepting an item");

  // The timestamp of the last update changes only when a recomputed result is produced.
  a_state_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rgpid_pkg::S_ROUND) |=> $stable(last_ms_r))
    else $error("timestamp of last update changed outside an update");

endmodule

// File: test/rgpid_result_checker.sv
`timescale 1ns / 1ps
// Watches the rate-gated PID controller's channels, predicts every result item and compares.
module rgpid_result_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_command,
  input  logic signed [15:0]                  in_error_in,
  input  logic [31:0]                         in_now_ms,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [31:0]                  out_control_value,
  input  logic                                out_recomputed,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rgpid_pkg::AddrW-1:0]         paddr,
  input  logic [rgpid_pkg::DataW-1:0]         pwdata,
  input  logic                                pready,
  output int                                  fail_count,
  output int                                  pending
);

  typedef struct {
    logic signed [31:0] control_value;
    logic               recomputed;
  } control_item_t;

  localparam longint OutMax = 64'sh0000_0000_7FFF_FFFF;
  localparam longint OutMin = -64'sh0000_0000_8000_0000;

  logic signed [31:0] kp;
  logic signed [31:0] ki;
  logic signed [31:0] kd;
  logic [15:0]        min_step;
  logic [30:0]        clamp_mag;

  logic signed [15:0] last_error;
  logic signed [31:0] integ_sum;
  logic [31:0]        last_stamp;
  logic signed [31:0] held_value;

  control_item_t expected_q[$];

  function automatic control_item_t next_control(input logic cmd,
                                                 input logic signed [15:0] err,
                                                 input logic [31:0] stamp);
    logic [31:0]   elapsed;
    longint        span;
    longint        acc;
    longint        bound;
    longint        slope;
    longint        total;
    longint        rounded;
    control_item_t res;
    elapsed = stamp - last_stamp;
    span = longint'({32'd0, elapsed});
    res.control_value = held_value;
    res.recomputed = 1'b0;
    if (elapsed >= {16'd0, min_step}) begin
      total = longint'(kp) * longint'(err);
      if (cmd == 1'b0) begin
        acc = longint'(integ_sum) + longint'(err) * span;
        bound = longint'({33'd0, clamp_mag});
        if (acc > bound) begin
          acc = bound;
        end else if (acc < -bound) begin
          acc = -bound;
        end
        integ_sum = acc[31:0];
        total = total + longint'(ki) * longint'(integ_sum);
      end
      slope = 0;
      if (elapsed != 32'd0) begin
        slope = ((longint'(err) - longint'(last_error)) * 64'sd65536) / span;
      end
      total = total + ((longint'(kd) * slope) >>> 16);
      rounded = (total + 64'sh8000) >>> 16;
      if (rounded > OutMax) begin
        rounded = OutMax;
      end else if (rounded < OutMin) begin
        rounded = OutMin;
      end
      last_error = err;
      last_stamp = stamp;
      held_value = rounded[31:0];
      res.control_value = held_value;
      res.recomputed = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    control_item_t want;
    if (!rst_n) begin
      kp = '0;
      ki = '0;
      kd = '0;
      min_step = rgpid_pkg::StepMsReset;
      clamp_mag = rgpid_pkg::IntegLimReset;
      last_error = '0;
      integ_sum = '0;
      last_stamp = '0;
      held_value = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item, control_value %0d recomputed %0b",
                   $time, out_control_value, out_recomputed);
          fail_count = fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_control_value !== want.control_value) begin
            $display("%0t: control_value expected %0d, actual %0d",
                     $time, want.control_value, out_control_value);
            fail_count = fail_count + 1;
          end
          if (out_recomputed !== want.recomputed) begin
            $display("%0t: recomputed expected %0b, actual %0b",
                     $time, want.recomputed, out_recomputed);
            fail_count = fail_count + 1;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[rgpid_pkg::AddrW-1:2])
          rgpid_pkg::RegPropGain:  kp = pwdata[31:0];
          rgpid_pkg::RegIntegGain: ki = pwdata[31:0];
          rgpid_pkg::RegDerivGain: kd = pwdata[31:0];
          rgpid_pkg::RegStepMs:    min_step = pwdata[15:0];
          rgpid_pkg::RegIntegLim:  clamp_mag = pwdata[30:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(next_control(in_command, in_error_in, in_now_ms));
      end
    end
    pending <= expected_q.size();
  end

endmodule

// File: test/rate_gated_pid_controller_tb.sv
`timescale 1ns / 1ps
// Testbench top for the rate-gated PID controller: stimulus, register setup and verdict.
module rate_gated_pid_controller_tb;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic                              in_command;
  logic signed [15:0]                in_error_in;
  logic [31:0]                       in_now_ms;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [31:0]                out_control_value;
  logic                              out_recomputed;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [rgpid_pkg::AddrW-1:0]       paddr;
  logic [rgpid_pkg::DataW-1:0]       pwdata;
  logic [rgpid_pkg::DataW-1:0]       prdata;
  logic                              pready;

  int          fail_count;
  int          pending;
  logic        calm = 1'b0;
  logic [31:0] clock_ms;
  logic [15:0] cur_step;

  rate_gated_pid_controller dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_error_in       (in_error_in),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_control_value (out_control_value),
    .out_recomputed    (out_recomputed),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  rgpid_result_checker result_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_error_in       (in_error_in),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_control_value (out_control_value),
    .out_recomputed    (out_recomputed),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 21);
  end

  function automatic bit in_gap();
    return !calm && ($urandom_range(0, 99) < 21);
  endfunction

  function automatic logic signed [31:0] small_gain();
    return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sd524288;
  endfunction

  function automatic logic signed [15:0] pick_error();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 16'sh7FFF;
    if (sel < 10) return 16'sh8000;
    if (sel < 50) return 16'($urandom_range(0, 600)) - 16'sd300;
    return 16'($urandom());
  endfunction

  task automatic send_item(input logic cmd, input logic signed [15:0] err,
                           input logic [31:0] stamp);
    while (in_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_error_in <= err;
    in_now_ms <= stamp;
    clock_ms = stamp;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [rgpid_pkg::RegIdxW-1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_regs(input logic signed [31:0] p, input logic signed [31:0] i,
                          input logic signed [31:0] d, input logic [15:0] s,
                          input logic [30:0] l);
    write_reg(rgpid_pkg::RegPropGain, p);
    write_reg(rgpid_pkg::RegIntegGain, i);
    write_reg(rgpid_pkg::RegDerivGain, d);
    write_reg(rgpid_pkg::RegStepMs, {16'd0, s});
    write_reg(rgpid_pkg::RegIntegLim, {1'b0, l});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_step = s;
  endtask

  // Timestamps often advance by about one step, so most items are updates; some
  // stay below the step, some jump or wrap, and a few are unrelated to the sequence.
  task automatic random_run(input int count);
    int unsigned sel;
    logic [31:0] delta;
    logic [31:0] stamp;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) delta = $urandom_range(0, cur_step);
      else if (sel < 65) delta = cur_step + $urandom_range(0, 20);
      else if (sel < 80) delta = cur_step + $urandom_range(0, 4 * cur_step + 100);
      else if (sel < 90) delta = $urandom();
      else delta = 32'd0;
      if ($urandom_range(0, 99) < 8) stamp = $urandom();
      else stamp = clock_ms + delta;
      send_item($urandom_range(0, 99) < 25, pick_error(), stamp);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= 1'b0;
    in_error_in <= '0;
    in_now_ms <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    clock_ms = '0;
    cur_step = rgpid_pkg::StepMsReset;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(1'b0, 16'sd1000, 32'd5);
    send_item(1'b0, 16'sd1000, 32'd10);
    wait_idle();
    set_regs(32'sh0001_0000, 32'sh0000_0100, 32'sh0000_8000, 16'd10, 31'd100000);
    send_item(1'b0, 16'sh7FFF, 32'd20);
    send_item(1'b0, 16'sh8000, 32'd30);
    send_item(1'b1, 16'sh8000, 32'd35);
    send_item(1'b1, 16'sd12345, 32'd45);
    send_item(1'b0, -16'sd1, 32'd60);
    send_item(1'b0, 16'sd0, 32'hFFFF_FFF0);
    send_item(1'b0, 16'sd77, 32'd5);
    send_item(1'b1, -16'sd77, 32'd12);
    wait_idle();
    set_regs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd0, 31'd0);
    send_item(1'b0, 16'sh7FFF, 32'd12);
    send_item(1'b0, 16'sh7FFF, 32'd12);
    send_item(1'b1, 16'sh8000, 32'd13);
    wait_idle();
    set_regs(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'hFFFF, 31'h7FFF_FFFF);
    send_item(1'b0, 16'sh7FFF, 32'd65547);
    send_item(1'b0, 16'sh7FFF, 32'd65548);
    send_item(1'b0, 16'sh8000, 32'd131083);
    send_item(1'b1, 16'sd0, 32'd201083);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: set_regs(small_gain(), small_gain(), small_gain(), 16'd10,
                    31'($urandom_range(0, 5000000)));
        1: set_regs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0, 31'h7FFF_FFFF);
        2: set_regs(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 31'd0);
        3: set_regs(small_gain(), small_gain(), small_gain(), 16'd1,
                    31'($urandom_range(0, 100000)));
        4: set_regs($urandom(), $urandom(), $urandom(), 16'($urandom_range(0, 65535)),
                    31'($urandom()));
        5: set_regs(small_gain(), small_gain(), small_gain(), 16'($urandom_range(0, 50)),
                    31'($urandom()));
        default: ;
      endcase
      if (ph == 2) begin
        calm <= 1'b1;
        random_run(100);
        calm <= 1'b0;
        random_run(25);
      end else begin
        random_run(125);
      end
    end

    wait_idle();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/rgpid_pkg.sv
hw/rtl/rate_gated_pid_controller.sv
test/rgpid_result_checker.sv
test/rate_gated_pid_controller_tb.sv
